>>> hdl/tkca_pkg.sv
package tkca_pkg;

  localparam int COST_W = 64;
  localparam int NODE_W = 32;
  localparam int RANK_W = 16;
  localparam int KEEP_W = 5;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

  // Longest route the rank counter has to number; ranks saturate one below it.
  localparam logic [63:0] MAX_ROUTE_ARCS = 64'd65536;
  localparam logic [RANK_W-1:0] RANK_LIMIT =
    ((MAX_ROUTE_ARCS - 64'd1) < 64'(16'hFFFF)) ? RANK_W'(MAX_ROUTE_ARCS - 64'd1)
                                                 : {RANK_W{1'b1}};

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [RANK_W-1:0] rank;
    logic [NODE_W-1:0] node;
  } entry_t;

  // What one cell hands to the next cell along the list.
  typedef struct packed {
    entry_t ent;
    logic   ev;
    logic   pos;
  } link_t;

  // One entry of the result queue.
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [RANK_W-1:0] rank;
    logic              valid;
  } oent_t;

  typedef struct packed {
    logic ins;
    logic clr;
    logic load;
    logic marker;
    logic shift;
  } ctl_t;

endpackage

>>> hdl/tkca_cell.sv
module tkca_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            cap_ok,
  input  logic            marker_slot,
  input  tkca_pkg::ctl_t   ctl,
  input  tkca_pkg::entry_t new_ent,
  input  tkca_pkg::link_t  left,
  output tkca_pkg::link_t  right,
  input  tkca_pkg::oent_t  from_right,
  output tkca_pkg::oent_t  oent
);
  import tkca_pkg::*;

  entry_t            ent;
  logic              valid;
  entry_t            ent_next;
  logic              valid_next;
  logic              ev;
  logic              pos;
  logic              ovalid;
  logic [NODE_W-1:0] onode;
  logic [RANK_W-1:0] orank;

  // An entry is displaced when the new arc is strictly costlier; equal costs stay ahead.
  always_comb begin
    ev = valid && cap_ok;
    pos = ev ? ($signed(ent.cost) < $signed(new_ent.cost)) : 1'b1;
    valid_next = cap_ok && left.ev;
    if (left.pos) begin
      ent_next = left.ent;
    end else if (pos) begin
      ent_next = new_ent;
    end else begin
      ent_next = ent;
    end
  end

  assign right = '{ent: ent, ev: ev, pos: pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.ins) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      ent <= ent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (ctl.load) begin
      ovalid <= ctl.marker ? marker_slot : valid_next;
    end else if (ctl.shift) begin
      ovalid <= from_right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      onode <= ctl.marker ? '0 : ent_next.node;
      orank <= ctl.marker ? '0 : ent_next.rank;
    end else if (ctl.shift) begin
      onode <= from_right.node;
      orank <= from_right.rank;
    end
  end

  assign oent = '{node: onode, rank: orank, valid: ovalid};

endmodule

>>> hdl/route_top_k_costliest_arcs.sv
// Channel  Handshake                Payload
// arc      arc_valid / arc_ready    arc_start, arc_weight, last_arc
// res      res_valid / res_ready    out_arc_start, out_rank, route_nonempty, last_result
// cfg      cfg_valid / cfg_ready    cfg_data (keep_count)
//
// A non-last arc is taken every cycle; each cell compares and shifts its entry in that same cycle.
// A last arc copies the list into the result queue, which gives one result per cycle of res_ready.
// A last arc waits while the previous route's results are queued, unless only the last is left and taken.
// Reset clears the list, the queue and the rank counter and sets keep_count to 16.
// A stalled result queue stalls only last arcs.
module route_top_k_costliest_arcs #(
  parameter int MAX_KEEP = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          arc_valid,
  output logic                          arc_ready,
  input  logic [tkca_pkg::NODE_W-1:0]   arc_start,
  input  logic signed [tkca_pkg::COST_W-1:0] arc_weight,
  input  logic                          last_arc,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [tkca_pkg::NODE_W-1:0]   out_arc_start,
  output logic [tkca_pkg::RANK_W-1:0]   out_rank,
  output logic                          route_nonempty,
  output logic                          last_result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tkca_pkg::KEEP_W-1:0]   cfg_data
);
  import tkca_pkg::*;

  logic [KEEP_W-1:0] keep_count;
  logic [RANK_W-1:0] cnt;
  logic [RANK_W-1:0] cnt_next;
  logic              nonempty;
  logic              accept;
  logic              q_free;
  ctl_t              ctl;
  entry_t            new_ent;
  link_t             link  [MAX_KEEP+1];
  oent_t             olink [MAX_KEEP+1];
  logic [MAX_KEEP-1:0] ev_vec;
  logic [MAX_KEEP-1:0] ov_vec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      keep_count <= cfg_data;
    end
  end

  assign q_free    = !olink[0].valid || (res_ready && !olink[1].valid);
  assign arc_ready = !last_arc || q_free;
  assign accept    = arc_valid && arc_ready;

  assign new_ent = '{cost: arc_weight, rank: cnt, node: arc_start};

  always_comb begin
    ctl.ins    = accept && !last_arc;
    ctl.clr    = accept && last_arc;
    ctl.load   = accept && last_arc;
    ctl.marker = (cnt == '0);
    ctl.shift  = res_valid && res_ready;
  end

  always_comb begin
    cnt_next = cnt;
    if (accept) begin
      if (last_arc) begin
        cnt_next = '0;
      end else if (cnt < RANK_LIMIT) begin
        cnt_next = cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      nonempty <= !ctl.marker;
    end
  end

  assign link[0]         = '{ent: new_ent, ev: 1'b1, pos: 1'b0};
  assign olink[MAX_KEEP] = '0;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    tkca_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cap_ok      ((i == 0) || (32'(keep_count) > 32'(i))),
      .marker_slot (i == 0),
      .ctl         (ctl),
      .new_ent     (new_ent),
      .left        (link[i]),
      .right       (link[i+1]),
      .from_right  (olink[i+1]),
      .oent        (olink[i])
    );
    assign ev_vec[i] = link[i+1].ev;
    assign ov_vec[i] = olink[i].valid;
  end

  assign res_valid      = olink[0].valid;
  assign out_arc_start  = olink[0].node;
  assign out_rank       = olink[0].rank;
  assign route_nonempty = nonempty;
  assign last_result    = !olink[1].valid;

  a_queue_prefix: assert property (@(posedge clk) disable iff (rst)
    (ov_vec & (ov_vec + 1'b1)) == '0)
    else $error("Result queue entries are not contiguous from the head.");

  a_list_prefix: assert property (@(posedge clk) disable iff (rst)
    (ev_vec & (ev_vec + 1'b1)) == '0)
    else $error("Kept list entries are not contiguous from the top.");

  a_rank_cleared: assert property (@(posedge clk) disable iff (rst)
    accept && last_arc |=> cnt == '0)
    else $error("Rank counter not cleared after the last arc of a route.");

  a_marker_single: assert property (@(posedge clk) disable iff (rst)
    accept && last_arc && cnt == '0 |=> ov_vec == MAX_KEEP'(1) && !route_nonempty)
    else $error("Single-arc route did not yield exactly one empty-route result.");

  a_list_empty_after: assert property (@(posedge clk) disable iff (rst)
    accept && last_arc |=> ev_vec == '0)
    else $error("Kept list not cleared after the last arc of a route.");

endmodule

>>> tb/route_top_k_costliest_arcs_checker.sv
module route_top_k_costliest_arcs_checker #(
  parameter int MAX_KEEP = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              arc_valid,
  input  logic                              arc_ready,
  input  logic [tkca_pkg::NODE_W-1:0]       arc_start,
  input  logic signed [tkca_pkg::COST_W-1:0] arc_weight,
  input  logic                              last_arc,
  input  logic                              res_valid,
  input  logic                              res_ready,
  input  logic [tkca_pkg::NODE_W-1:0]       out_arc_start,
  input  logic [tkca_pkg::RANK_W-1:0]       out_rank,
  input  logic                              route_nonempty,
  input  logic                              last_result,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [tkca_pkg::KEEP_W-1:0]       cfg_data,
  output int                                mismatches,
  output int                                backlog
);
  import tkca_pkg::*;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [RANK_W-1:0] rank;
    logic              nonempty;
    logic              last;
  } route_result_t;

  route_result_t     due_results[$];
  entry_t            kept_list[MAX_KEEP];
  int                kept_len = 0;
  logic [RANK_W-1:0] next_rank = '0;
  logic [KEEP_W-1:0] keep_reg = KEEP_RESET;
  int                miss_count = 0;
  int                due_count = 0;

  assign mismatches = miss_count;
  assign backlog = due_count;

  function automatic int keep_limit();
    int k;
    k = int'(keep_reg);
    if (k == 0) k = 1;
    if (k > MAX_KEEP) k = MAX_KEEP;
    return k;
  endfunction

  task automatic insert_arc(input logic [NODE_W-1:0] node,
                            input logic signed [COST_W-1:0] cost,
                            input logic last);
    int cap;
    int n;
    int p;
    int i;
    int newn;
    route_result_t res;
    cap = keep_limit();
    if (last && next_rank == '0) begin
      res.node = '0;
      res.rank = '0;
      res.nonempty = 1'b0;
      res.last = 1'b1;
      due_results = {due_results, res};
      kept_len = 0;
      next_rank = '0;
    end else begin
      n = (kept_len > cap) ? cap : kept_len;
      p = 0;
      while (p < n && !($signed(kept_list[p].cost) < cost)) p++;
      if (p < cap) begin
        i = (n < cap) ? n : cap - 1;
        while (i > p) begin
          kept_list[i] = kept_list[i-1];
          i--;
        end
        kept_list[p].cost = cost;
        kept_list[p].rank = next_rank;
        kept_list[p].node = node;
        newn = (n + 1 < cap) ? n + 1 : cap;
      end else begin
        newn = n;
      end
      kept_len = newn;
      if (next_rank < RANK_LIMIT) next_rank++;
      if (last) begin
        for (i = 0; i < newn; i++) begin
          res.node = kept_list[i].node;
          res.rank = kept_list[i].rank;
          res.nonempty = 1'b1;
          res.last = (i == newn - 1);
          due_results = {due_results, res};
        end
        kept_len = 0;
        next_rank = '0;
      end
    end
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      miss_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    route_result_t want;
    if (rst) begin
      due_results.delete();
      kept_len = 0;
      next_rank = '0;
      keep_reg = KEEP_RESET;
    end else begin
      if (res_valid && res_ready) begin
        if (due_results.size() == 0) begin
          miss_count++;
          $display("%0t: unexpected result, expected none, actual start %0h rank %0d %b %b",
                   $time, out_arc_start, out_rank, route_nonempty, last_result);
        end else begin
          want = due_results.pop_front();
          check_field("out_arc_start", 64'(want.node), 64'(out_arc_start));
          check_field("out_rank", 64'(want.rank), 64'(out_rank));
          check_field("route_nonempty", 64'(want.nonempty), 64'(route_nonempty));
          check_field("last_result", 64'(want.last), 64'(last_result));
        end
      end
      if (arc_valid && arc_ready) insert_arc(arc_start, arc_weight, last_arc);
      if (cfg_valid && cfg_ready) keep_reg = cfg_data;
    end
    due_count <= due_results.size();
  end

endmodule

>>> tb/route_top_k_costliest_arcs_tb.sv
module route_top_k_costliest_arcs_tb;
  import tkca_pkg::*;

  localparam int KEEP_MAX = 16;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_LIMIT = 3000;
  localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};
  localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     arc_valid = 1'b0;
  logic                     arc_ready;
  logic [NODE_W-1:0]        arc_start = '0;
  logic signed [COST_W-1:0] arc_weight = '0;
  logic                     last_arc = 1'b0;
  logic                     res_valid;
  logic                     res_ready = 1'b0;
  logic [NODE_W-1:0]        out_arc_start;
  logic [RANK_W-1:0]        out_rank;
  logic                     route_nonempty;
  logic                     last_result;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [KEEP_W-1:0]        cfg_data = '0;

  int idle_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int rx_wait = 0;
  int quiet_cycles = 0;
  int mismatches;
  int backlog;

  route_top_k_costliest_arcs #(.MAX_KEEP(KEEP_MAX)) DUT (
    .clk(clk), .rst(rst),
    .arc_valid(arc_valid), .arc_ready(arc_ready),
    .arc_start(arc_start), .arc_weight(arc_weight), .last_arc(last_arc),
    .res_valid(res_valid), .res_ready(res_ready),
    .out_arc_start(out_arc_start), .out_rank(out_rank),
    .route_nonempty(route_nonempty), .last_result(last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  route_top_k_costliest_arcs_checker #(.MAX_KEEP(KEEP_MAX)) arc_checker (
    .clk(clk), .rst(rst),
    .arc_valid(arc_valid), .arc_ready(arc_ready),
    .arc_start(arc_start), .arc_weight(arc_weight), .last_arc(last_arc),
    .res_valid(res_valid), .res_ready(res_ready),
    .out_arc_start(out_arc_start), .out_rank(out_rank),
    .route_nonempty(route_nonempty), .last_result(last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .backlog(backlog)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      rx_wait <= 0;
    end else if (holds_served != holds_asked) begin
      res_ready <= 1'b0;
      rx_wait <= LONG_HOLD;
      holds_served <= holds_served + 1;
    end else if (rx_wait > 0) begin
      res_ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      res_ready <= 1'b0;
      rx_wait <= $urandom_range(0, 16);
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((arc_valid && arc_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_arc(input logic [NODE_W-1:0] node, input logic signed [COST_W-1:0] cost,
                          input logic last);
    arc_valid <= 1'b1;
    arc_start <= node;
    arc_weight <= cost;
    last_arc <= last;
    do @(posedge clk); while (!arc_ready);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      arc_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic settle();
    arc_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [COST_W-1:0] pick_cost();
    case ($urandom_range(0, 7))
      0, 1, 2: pick_cost = {$urandom, $urandom};
      3:       pick_cost = COST_MAX;
      4:       pick_cost = COST_MIN;
      default: pick_cost = COST_W'($urandom_range(0, 6)) - COST_W'(3);
    endcase
  endfunction

  function automatic logic [NODE_W-1:0] pick_node();
    case ($urandom_range(0, 9))
      0:       pick_node = '0;
      1:       pick_node = '1;
      default: pick_node = $urandom;
    endcase
  endfunction

  function automatic int pick_route_len();
    case ($urandom_range(0, 9))
      0:       pick_route_len = 1;
      1:       pick_route_len = $urandom_range(17, 24);
      default: pick_route_len = $urandom_range(2, 10);
    endcase
  endfunction

  initial begin
    int phase;
    int sent;
    int len;
    int k;
    logic [KEEP_W-1:0] keep;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_arc(32'h0000_0000, COST_MIN, 1'b0);
    send_arc(32'hFFFF_FFFF, COST_MAX, 1'b0);
    send_arc(32'h0000_0005, COST_W'(0), 1'b0);
    send_arc(32'h0000_0007, COST_W'(-1), 1'b0);
    send_arc(32'h0000_0009, COST_MAX, 1'b0);
    send_arc(32'h0000_0003, COST_W'(-1), 1'b1);
    send_arc(32'hFFFF_FFFF, COST_MAX, 1'b1);
    send_arc(32'h0000_0000, COST_MIN, 1'b1);

    settle();
    write_keep(KEEP_W'(1));
    send_arc(32'd1, COST_W'(100), 1'b0);
    send_arc(32'd2, COST_W'(50), 1'b0);
    send_arc(32'd3, COST_W'(200), 1'b0);
    send_arc(32'd4, COST_W'(200), 1'b1);

    settle();
    write_keep(KEEP_W'(0));
    send_arc(32'd5, COST_W'(-5), 1'b0);
    send_arc(32'd6, COST_W'(-4), 1'b1);

    settle();
    write_keep(KEEP_W'(31));
    send_arc(32'd7, COST_W'(1), 1'b0);
    send_arc(32'd8, COST_W'(1), 1'b1);

    // The keep count is lowered while a route is half way through.
    settle();
    write_keep(KEEP_W'(4));
    send_arc(32'd10, COST_W'(10), 1'b0);
    send_arc(32'd11, COST_W'(40), 1'b0);
    send_arc(32'd12, COST_W'(20), 1'b0);
    send_arc(32'd13, COST_W'(30), 1'b0);
    send_arc(32'd14, COST_W'(50), 1'b0);
    settle();
    write_keep(KEEP_W'(2));
    send_arc(32'd15, COST_W'(35), 1'b1);

    for (phase = 0; phase < 10; phase++) begin
      settle();
      case (phase)
        0:       keep = KEEP_W'(1);
        1:       keep = KEEP_W'(16);
        2:       keep = KEEP_W'(0);
        3:       keep = KEEP_W'(31);
        default: keep = ($urandom_range(0, 4) == 0) ? KEEP_W'($urandom_range(17, 31))
                                                    : KEEP_W'($urandom_range(1, 16));
      endcase
      write_keep(keep);
      if (phase >= 8) begin
        idle_pct <= 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       idle_pct <= 0;
          1:       idle_pct <= 10;
          2:       idle_pct <= 30;
          default: idle_pct <= 60;
        endcase
      end
      if (phase == 4) holds_asked <= holds_asked + 1;
      sent = 0;
      while (sent < 21) begin
        len = (phase == 4) ? $urandom_range(1, 3) : pick_route_len();
        for (k = 0; k < len; k++) send_arc(pick_node(), pick_cost(), k == len - 1);
        sent += len;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
